/* hw/rtl/wrsi_pkg.sv */
package wrsi_pkg;

	// Fixed widths of the channel payloads and the configuration register.
	localparam int PRICE_IN_W = 32;
	localparam int RSI_W      = 15;
	localparam int PERIOD_W   = 8;

	// Configuration port.
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;
	localparam logic [APB_AW-3:0] REG_PERIOD = '0;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;

	// RSI of a series with no losses, times 256.
	localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;

	// Warm-up counter value once the averages are seeded.
	localparam logic [PERIOD_W-1:0] SEEDED = 8'd255;

	// Quotient bits the divider produces per cycle when dividing by the period.
	localparam int NSUB = 4;

	// Request to the shared divider.
	typedef struct packed {
		logic start;
		logic narrow;
	} div_ctl_t;

endpackage

/* hw/rtl/wrsi_in_if.sv */
interface wrsi_in_if import wrsi_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [PRICE_IN_W-1:0] close_price;
	logic                  restart;

	modport source (output valid, output close_price, output restart, input ready);
	modport sink (input valid, input close_price, input restart, output ready);

endinterface

/* hw/rtl/wrsi_out_if.sv */
interface wrsi_out_if import wrsi_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [RSI_W-1:0] rsi_value;

	modport source (output valid, output rsi_value, input ready);
	modport sink (input valid, input rsi_value, output ready);

endinterface

/* hw/rtl/wrsi_cfg.sv */
module wrsi_cfg import wrsi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	output logic [PERIOD_W-1:0] period
);

	logic [PERIOD_W-1:0] period_q;
	logic                wr_en;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_PERIOD);

	// Period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (wr_en) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	// Read decode; unmapped words read as zero.
	always_comb begin
		unique case (paddr[APB_AW-1:2])
			REG_PERIOD: prdata = APB_DW'(period_q);
			default:    prdata = '0;
		endcase
	end

	assign period = period_q;

endmodule

/* hw/rtl/wrsi_div.sv */
module wrsi_div import wrsi_pkg::*; #(
	parameter int SUM_W = 56
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_ctl_t               ctl,
	input  logic [SUM_W+RSI_W-1:0] dividend,
	input  logic [SUM_W:0]         divisor,
	output logic                   done,
	output logic [SUM_W-1:0]       quotient
);

	localparam int MUL_W   = SUM_W + RSI_W;
	localparam int DN_W    = SUM_W + PERIOD_W;
	localparam int NSTEP   = (DN_W + NSUB - 1) / NSUB;
	localparam int NR_W    = NSTEP * NSUB;
	localparam int MAXSTEP = (NSTEP > RSI_W) ? NSTEP : RSI_W;
	localparam int CNT_W   = $clog2(MAXSTEP + 1);
	localparam int DV_W    = SUM_W + 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             narrow_q;
	logic [DV_W-1:0]  rem_q;
	logic [DV_W-1:0]  dv_q;
	logic [NR_W-1:0]  sh_q;

	logic [PERIOD_W-1:0] nr;
	logic [PERIOD_W:0]   nt;
	logic [NR_W-1:0]     nsh;
	logic [DV_W:0]       wt;
	logic [DV_W:0]       wdiff;
	logic                wge;

	// Narrow mode: several restoring steps against the 8-bit period per cycle.
	// The shift register moves dividend bits out at the top and quotient bits in below.
	always_comb begin
		nr  = rem_q[PERIOD_W-1:0];
		nsh = sh_q;
		nt  = '0;
		for (int k = 0; k < NSUB; k++) begin
			nt  = {nr, nsh[NR_W-1]};
			nsh = {nsh[NR_W-2:0], 1'b0};
			if (nt >= {1'b0, dv_q[PERIOD_W-1:0]}) begin
				nt     = nt - {1'b0, dv_q[PERIOD_W-1:0]};
				nsh[0] = 1'b1;
			end
			nr = nt[PERIOD_W-1:0];
		end
	end

	// Wide mode: one restoring step per cycle against the full divisor.
	assign wt    = {rem_q, sh_q[NR_W-1]};
	assign wdiff = wt - {1'b0, dv_q};
	assign wge   = (wt >= {1'b0, dv_q});

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.narrow ? CNT_W'(NSTEP) : CNT_W'(RSI_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers. In wide mode the quotient is known
	// to fit the RSI width, so the remainder starts from the dividend's upper bits.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			narrow_q <= ctl.narrow;
			dv_q     <= divisor;
			if (ctl.narrow) begin
				rem_q <= '0;
				sh_q  <= NR_W'(dividend[DN_W-1:0]);
			end else begin
				rem_q <= DV_W'(dividend[MUL_W-1:RSI_W]);
				sh_q  <= {dividend[RSI_W-1:0], {(NR_W-RSI_W){1'b0}}};
			end
		end else if (busy_q) begin
			if (narrow_q) begin
				rem_q <= DV_W'(nr);
				sh_q  <= nsh;
			end else begin
				rem_q <= wge ? wdiff[DV_W-1:0] : wt[DV_W-1:0];
				sh_q  <= {sh_q[NR_W-2:0], wge};
			end
		end
	end

	assign done     = done_q;
	assign quotient = sh_q[SUM_W-1:0];

endmodule

/* hw/rtl/wilder_rsi_indicator_core.sv */
// Wilder RSI engine. Each transfer on price_ch carries one closing price; every
// price that completes the seed of the averages, and every price after it, gives
// one transfer on rsi_ch holding 256*RSI (0 to 25600). The period register (byte
// address 0, reset 14, zero acts as 1) is to be written by the user only while
// the block is idle; the block itself does not enforce this. Items are handled
// one at a time under a small sequencer. For a price that produces an RSI, the
// shared divider divides the two averages by the period four quotient bits per
// cycle and then divides for the RSI one bit per cycle; the RSI division is
// skipped when the loss average is zero. A finished result waits in an output
// register, so the next price is taken while it is still pending; a later result
// that finds that register still full waits in the last state until the register
// is taken.
module wilder_rsi_indicator_core import wrsi_pkg::*; #(
	parameter int PRICE_BITS    = 32,
	parameter int AVG_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	wrsi_in_if.sink           price_ch,
	wrsi_out_if.source        rsi_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int AVG_W = PRICE_BITS + AVG_FRAC_BITS;
	localparam int SUM_W = AVG_W + PERIOD_W;
	localparam int MUL_W = SUM_W + RSI_W;
	localparam int DV_W  = SUM_W + 1;

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ACC  = 4'd1;
	localparam logic [3:0] S_STG  = 4'd2;
	localparam logic [3:0] S_DVG  = 4'd3;
	localparam logic [3:0] S_STL  = 4'd4;
	localparam logic [3:0] S_DVL  = 4'd5;
	localparam logic [3:0] S_RSM  = 4'd6;
	localparam logic [3:0] S_RSS  = 4'd7;
	localparam logic [3:0] S_RSD  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]          state_q;
	logic                have_last_q;
	logic [PERIOD_W-1:0] warm_q;
	logic                seed_q;
	logic                out_valid_q;
	logic [PRICE_BITS-1:0] last_q;
	logic [PRICE_BITS-1:0] up_q;
	logic [PRICE_BITS-1:0] dn_q;
	logic [SUM_W-1:0]    gain_q;
	logic [SUM_W-1:0]    loss_q;
	logic [MUL_W-1:0]    mul_q;
	logic [RSI_W-1:0]    res_q;
	logic [RSI_W-1:0]    rsi_q;

	logic [PERIOD_W-1:0]   period;
	logic [PERIOD_W-1:0]   p_eff;
	logic [PERIOD_W-1:0]   warm_n;
	logic [PRICE_BITS-1:0] price;
	logic                  in_acc;
	logic                  first;
	logic                  seeded;
	logic                  out_load;
	logic [SUM_W-1:0]      gm;
	logic [SUM_W-1:0]      lm;
	logic [SUM_W-1:0]      mul_a;
	logic [RSI_W-1:0]      mul_k;
	logic [MUL_W-1:0]      mul_p;
	div_ctl_t              div_ctl;
	logic [MUL_W-1:0]      div_dividend;
	logic [DV_W-1:0]       div_divisor;
	logic                  div_done;
	logic [SUM_W-1:0]      div_q;

	wrsi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.period  (period)
	);

	// Handshakes and derived values.
	assign price_ch.ready  = (state_q == S_IDLE);
	assign in_acc          = price_ch.valid && price_ch.ready;
	assign price           = PRICE_BITS'(price_ch.close_price);
	assign first           = price_ch.restart || !have_last_q;
	assign p_eff           = (period == '0) ? PERIOD_W'(1) : period;
	assign warm_n          = warm_q + 1'b1;
	assign seeded          = (warm_q == SEEDED);
	assign out_load        = (state_q == S_OUT) && (!out_valid_q || rsi_ch.ready);
	assign gm              = SUM_W'({up_q, {AVG_FRAC_BITS{1'b0}}});
	assign lm              = SUM_W'({dn_q, {AVG_FRAC_BITS{1'b0}}});
	assign rsi_ch.valid     = out_valid_q;
	assign rsi_ch.rsi_value = rsi_q;

	// Shared multiplier: average times (period-1) for smoothing, gain times 25600 for RSI.
	assign mul_a = (state_q == S_STG) ? loss_q : gain_q;
	assign mul_k = (state_q == S_RSM) ? RSI_FULL : RSI_W'(p_eff - 1'b1);
	assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_k);

	// Divider requests: gain and loss by the period, then the RSI ratio.
	always_comb begin
		div_ctl.start = (state_q == S_STG) || (state_q == S_STL) || (state_q == S_RSS);
		div_ctl.narrow = (state_q != S_RSS);
		div_divisor = DV_W'(p_eff);
		div_dividend = '0;
		case (state_q)
			S_STG:   div_dividend = seed_q ? MUL_W'(gain_q) : mul_q + MUL_W'(gm);
			S_STL:   div_dividend = seed_q ? MUL_W'(loss_q) : mul_q + MUL_W'(lm);
			S_RSS: begin
				div_dividend = mul_q;
				div_divisor  = DV_W'(gain_q) + DV_W'(loss_q);
			end
			default: div_dividend = '0;
		endcase
	end

	wrsi_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_last_q <= 1'b0;
			warm_q      <= '0;
			seed_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills from the sequencer and empties on a transfer.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsi_ch.valid && rsi_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						have_last_q <= 1'b1;
						if (first) begin
							warm_q <= '0;
						end else begin
							state_q <= S_ACC;
						end
					end
				end
				S_ACC: begin
					if (!seeded) begin
						if (warm_n < p_eff) begin
							warm_q  <= warm_n;
							state_q <= S_IDLE;
						end else begin
							warm_q  <= SEEDED;
							seed_q  <= 1'b1;
							state_q <= S_STG;
						end
					end else begin
						seed_q  <= 1'b0;
						state_q <= S_STG;
					end
				end
				S_STG: state_q <= S_DVG;
				S_DVG: begin
					if (div_done) begin
						state_q <= S_STL;
					end
				end
				S_STL: state_q <= S_DVL;
				S_DVL: begin
					if (div_done) begin
						state_q <= S_RSM;
					end
				end
				S_RSM: state_q <= (loss_q == '0) ? S_OUT : S_RSS;
				S_RSS: state_q <= S_RSD;
				S_RSD: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers. During the seed phase the averages hold running sums.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					last_q <= price;
					if (first) begin
						gain_q <= '0;
						loss_q <= '0;
					end else begin
						up_q <= (price > last_q) ? price - last_q : '0;
						dn_q <= (price < last_q) ? last_q - price : '0;
					end
				end
			end
			S_ACC: begin
				if (!seeded) begin
					gain_q <= gain_q + gm;
					loss_q <= loss_q + lm;
				end else begin
					mul_q <= mul_p;
				end
			end
			S_STG: mul_q <= mul_p;
			S_DVG: begin
				if (div_done) begin
					gain_q <= div_q;
				end
			end
			S_DVL: begin
				if (div_done) begin
					loss_q <= div_q;
				end
			end
			S_RSM: begin
				mul_q <= mul_p;
				if (loss_q == '0) begin
					res_q <= RSI_FULL;
				end
			end
			S_RSD: begin
				if (div_done) begin
					res_q <= div_q[RSI_W-1:0];
				end
			end
			S_OUT: begin
				if (out_load) begin
					rsi_q <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// A delivered RSI never exceeds the full-scale value.
	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsi_ch.valid |-> (rsi_ch.rsi_value <= RSI_FULL))
		else $error("RSI result above full scale");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DVG || state_q == S_DVL || state_q == S_RSD))
		else $error("divider finished outside a wait state");

	// The RSI division is only started with a nonzero loss average.
	a_rsi_div_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RSS) |-> (loss_q != '0))
		else $error("RSI division started with zero loss average");

	// Once seeded, the averages stay seeded until a new series starts.
	a_seed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(seeded && !(in_acc && first)) |=> seeded)
		else $error("seeded state lost without a restart");
`endif

endmodule

/* tb/sv/rsi_checker.sv */
// Watches the price and RSI channels and the register port, predicts every RSI
// from the accepted prices and compares each RSI transfer with the oldest prediction.
module rsi_checker import wrsi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	wrsi_in_if                price_ch,
	wrsi_out_if               rsi_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [APB_AW-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};
	localparam int REPORT_LIMIT = 10;

	// Shadow of the period register and of the indicator state.
	logic [PERIOD_W-1:0]   period_copy;
	logic [PRICE_IN_W-1:0] prev_price;
	logic                  have_prev;
	logic [PERIOD_W-1:0]   moves_seen;
	logic [95:0]           gain_avg;
	logic [95:0]           loss_avg;

	logic [RSI_W-1:0] rsi_due[$];
	logic [RSI_W-1:0] next_rsi;
	logic [RSI_W-1:0] want_rsi;
	int               reported = 0;

	// Counts a failure and describes the first few of them.
	task automatic flag(input string msg);
		errors++;
		if (reported < REPORT_LIMIT) begin
			reported++;
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	// Advances the shadow state by one price; returns 1 when the price yields an RSI.
	function automatic bit predict_rsi(input logic [PRICE_IN_W-1:0] price, input logic fresh,
		output logic [RSI_W-1:0] rsi);
		logic [PRICE_IN_W-1:0] diff;
		logic [95:0]           up_move;
		logic [95:0]           down_move;
		logic [95:0]           divisor;
		logic [95:0]           scaled;
		rsi = '0;
		divisor = (period_copy == '0) ? 96'd1 : {88'd0, period_copy};
		// A new series only records its first price.
		if (fresh || !have_prev) begin
			prev_price = price;
			have_prev = 1'b1;
			moves_seen = '0;
			gain_avg = '0;
			loss_avg = '0;
			return 1'b0;
		end
		up_move = '0;
		down_move = '0;
		if (price > prev_price) begin
			diff = price - prev_price;
			up_move = {64'd0, diff} << FRAC_BITS;
		end else if (price < prev_price) begin
			diff = prev_price - price;
			down_move = {64'd0, diff} << FRAC_BITS;
		end
		prev_price = price;
		if (moves_seen != SEEDED) begin
			// Seed phase: sum the moves, then divide once enough have been seen.
			gain_avg = gain_avg + up_move;
			loss_avg = loss_avg + down_move;
			moves_seen = moves_seen + 8'd1;
			if ({88'd0, moves_seen} < divisor)
				return 1'b0;
			gain_avg = gain_avg / divisor;
			loss_avg = loss_avg / divisor;
			moves_seen = SEEDED;
		end else begin
			gain_avg = (gain_avg * (divisor - 96'd1) + up_move) / divisor;
			loss_avg = (loss_avg * (divisor - 96'd1) + down_move) / divisor;
		end
		if (loss_avg == '0) begin
			rsi = RSI_FULL;
		end else begin
			scaled = (gain_avg * {81'd0, RSI_FULL}) / (gain_avg + loss_avg);
			rsi = scaled[RSI_W-1:0];
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_copy = PERIOD_RESET;
			prev_price = '0;
			have_prev = 1'b0;
			moves_seen = '0;
			gain_avg = '0;
			loss_avg = '0;
			rsi_due.delete();
			errors = 0;
		end else begin
			// An RSI transfer is matched against the oldest prediction.
			if (rsi_ch.valid && rsi_ch.ready) begin
				if (rsi_due.size() == 0) begin
					flag($sformatf("rsi_value %0d arrived with nothing expected", rsi_ch.rsi_value));
				end else begin
					want_rsi = rsi_due.pop_front();
					if (rsi_ch.rsi_value !== want_rsi)
						flag($sformatf("rsi_value expected %0d, got %0d", want_rsi,
							rsi_ch.rsi_value));
				end
			end
			// A price transfer advances the prediction.
			if (price_ch.valid && price_ch.ready &&
				predict_rsi(price_ch.close_price, price_ch.restart, next_rsi))
				rsi_due = {rsi_due, next_rsi};
			// Register writes update the shadow; reads must return it.
			if (psel && penable && pready && paddr == PERIOD_ADDR) begin
				if (pwrite)
					period_copy = pwdata[PERIOD_W-1:0];
				else if (prdata !== APB_DW'(period_copy))
					flag($sformatf("period read expected %0d, got %0d", period_copy, prdata));
			end
		end
		pending = rsi_due.size();
	end

endmodule

/* tb/sv/testbench.sv */
// Drives prices and register settings into the RSI core and gives the verdict.
module testbench;
	import wrsi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [APB_AW-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};
	localparam int ITEM_TARGET  = 1800;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_GAP      = 16;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                errors;
	int                pending;
	int                items_sent = 0;
	int                quiet_cycles = 0;
	logic              calm = 1'b0;

	wrsi_in_if  price_ch ();
	wrsi_out_if rsi_ch ();

	wilder_rsi_indicator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.price_ch (price_ch),
		.rsi_ch   (rsi_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rsi_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.price_ch (price_ch),
		.rsi_ch   (rsi_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle cycles before each transfer; none during calm stretches.
	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Sends one price and returns once the transfer has happened.
	task automatic send_price(input logic [PRICE_IN_W-1:0] value, input logic fresh);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			price_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		price_ch.valid <= 1'b1;
		price_ch.close_price <= value;
		price_ch.restart <= fresh;
		do @(posedge clk); while (!price_ch.ready);
		items_sent++;
	endtask

	// Holds prices back until every predicted RSI has been received.
	task automatic drain_results();
		@(negedge clk);
		price_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Writes the period once the core is idle, then reads it back.
	task automatic set_period(input logic [PERIOD_W-1:0] value);
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= PERIOD_ADDR;
		pwdata <= APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// The RSI receiver drops ready for a random gap before each transfer, with no gap during calm stretches.
	initial begin
		int gap;
		rsi_ch.ready = 1'b0;
		forever begin
			gap = draw_gap();
			@(negedge clk);
			if (gap > 0) begin
				rsi_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsi_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsi_ch.valid);
		end
	end

	// Ends the run when nothing has moved for too long.
	always @(posedge clk) begin
		if ((price_ch.valid && price_ch.ready) || (rsi_ch.valid && rsi_ch.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		logic [PRICE_IN_W-1:0] walk;
		logic [PERIOD_W-1:0]   next_period;
		logic [PRICE_IN_W-1:0] opening[16];
		int                    phase;
		int                    phase_len;
		int                    kind;
		price_ch.valid = 1'b0;
		price_ch.close_price = '0;
		price_ch.restart = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset period: full-scale swings, flat moves, seed and one smoothed step.
		opening = '{32'd5, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0,
			32'd1, 32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'd3, 32'd3, 32'd9,
			32'hAAAA_AAAA};
		foreach (opening[i])
			send_price(opening[i], 1'b0);

		// Period of one: flat series, pure gain, pure loss, restarts.
		set_period(8'd1);
		send_price(32'd100, 1'b1);
		send_price(32'd100, 1'b0);
		send_price(32'd200, 1'b0);
		send_price(32'd50, 1'b0);
		send_price(32'd7, 1'b1);
		send_price(32'd7, 1'b0);
		send_price(32'd8, 1'b0);

		// Random phases, each under its own period; series may span phases.
		walk = 32'd8;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 19);
			if (phase == 0)
				next_period = 8'd255;
			else if (phase == 1 || kind == 0)
				next_period = 8'd0;
			else if (kind == 1)
				next_period = 8'd1;
			else if (kind == 2)
				next_period = 8'($urandom_range(21, 254));
			else
				next_period = 8'($urandom_range(2, 20));
			phase++;
			set_period(next_period);
			calm = ($urandom_range(0, 3) == 0);
			phase_len = (next_period > 8'd40) ? next_period + $urandom_range(10, 50)
				: $urandom_range(20, 120);
			if ($urandom_range(0, 1) == 1) begin
				walk = $urandom;
				send_price(walk, 1'b1);
			end
			repeat (phase_len) begin
				if ($urandom_range(0, 99) == 0)
					drain_results();
				kind = $urandom_range(0, 99);
				if (kind < 1) begin
					walk = $urandom;
					send_price(walk, 1'b1);
				end else begin
					if (kind < 50)
						walk = walk + $urandom_range(0, 200) - 32'd100;
					else if (kind < 65)
						walk = walk;
					else if (kind < 75)
						walk = walk + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
					else if (kind < 85)
						walk = $urandom;
					else if (kind < 90)
						walk = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
					else if (kind < 95)
						walk = walk + $urandom_range(0, 50);
					else
						walk = walk - $urandom_range(0, 50);
					send_price(walk, 1'b0);
				end
			end
		end

		// Let the last results arrive, then a little longer for strays.
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
